// ===== src/sha1de_pkg.sv =====
// sha1de_pkg: types, constants and helper functions shared by the sha1 digest engine
// no dependencies; imported by the controller, datapath and top level

package sha1de_pkg;

  localparam int unsigned WORD_W     = 32;
  localparam int unsigned LEN_W      = 61;
  localparam int unsigned NUM_HASH   = 5;
  localparam int unsigned WIN_DEPTH  = 16;
  localparam int unsigned NUM_ROUNDS = 80;

  localparam logic [31:0] IV_0 = 32'h6745_2301;
  localparam logic [31:0] IV_1 = 32'hEFCD_AB89;
  localparam logic [31:0] IV_2 = 32'h98BA_DCFE;
  localparam logic [31:0] IV_3 = 32'h1032_5476;
  localparam logic [31:0] IV_4 = 32'hC3D2_E1F0;

  localparam logic [31:0] K_0 = 32'h5A82_7999;
  localparam logic [31:0] K_1 = 32'h6ED9_EBA1;
  localparam logic [31:0] K_2 = 32'h8F1B_BCDC;
  localparam logic [31:0] K_3 = 32'hCA62_C1D6;

  localparam logic [31:0] PAD_MARKER = 32'h8000_0000;

  localparam logic [2:0] FULL_BYTES = 3'd4;
  localparam logic [2:0] LAST_IDX   = 3'd4;
  localparam logic [3:0] POS_LEN_HI = 4'd14;
  localparam logic [3:0] POS_LEN_LO = 4'd15;
  localparam logic [6:0] ROUND_LAST = 7'd79;
  localparam logic [6:0] ROUND_SCHED = 7'd16;
  localparam logic [6:0] ROUND_P1   = 7'd20;
  localparam logic [6:0] ROUND_P2   = 7'd40;
  localparam logic [6:0] ROUND_P3   = 7'd60;

  typedef enum logic [2:0] {
    SRC_INPUT,
    SRC_MARKER,
    SRC_ZERO,
    SRC_LEN_HI,
    SRC_LEN_LO
  } push_src_e;

  typedef struct packed {
    logic       push;
    push_src_e  src;
    logic       pad_in_word;
    logic [2:0] byte_count;
    logic       len_add;
    logic       work_load;
    logic       round_en;
    logic [6:0] round_idx;
    logic       chain_add;
    logic       chain_init;
    logic [2:0] out_idx;
  } cmd_t;

  function automatic logic [31:0] rotl1(input logic [31:0] x);
    return {x[30:0], x[31]};
  endfunction

  function automatic logic [31:0] rotl5(input logic [31:0] x);
    return {x[26:0], x[31:27]};
  endfunction

  function automatic logic [31:0] rotl30(input logic [31:0] x);
    return {x[1:0], x[31:2]};
  endfunction

  // keep n leading bytes, then the 0x80 marker; n of 4 or more returns w unchanged
  function automatic logic [31:0] pad_last_word(input logic [31:0] w, input logic [2:0] n);
    logic [31:0] r;
    case (n)
      3'd0: r = PAD_MARKER;
      3'd1: r = {w[31:24], 24'h80_0000};
      3'd2: r = {w[31:16], 16'h8000};
      3'd3: r = {w[31:8], 8'h80};
      default: r = w;
    endcase
    return r;
  endfunction

endpackage

// ===== src/sha1de_if.sv =====
// sha1de_in_if / sha1de_out_if: valid/ready channels of the sha1 digest engine
// no dependencies

interface sha1de_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] data_word;
  logic [2:0]  valid_bytes;
  logic        last_word;

  modport source (output valid, data_word, valid_bytes, last_word, input ready);
  modport sink   (input valid, data_word, valid_bytes, last_word, output ready);
endinterface

interface sha1de_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_digest;

  modport source (output valid, digest_word, word_index, last_digest, input ready);
  modport sink   (input valid, digest_word, word_index, last_digest, output ready);
endinterface

// ===== src/sha1de_ctrl.sv =====
// sha1de_ctrl: sequencer for word intake, padding, rounds and digest readout
// depends on sha1de_pkg

module sha1de_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [2:0]        in_bytes_i,
  input  logic              in_last_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output sha1de_pkg::cmd_t  cmd_o
);
  import sha1de_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ROUND = 3'd1;
  localparam logic [2:0] S_FINAL = 3'd2;
  localparam logic [2:0] S_PAD   = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0] state_q, state_d;
  logic [6:0] round_q, round_d;
  logic [3:0] pos_q, pos_d;
  logic [2:0] idx_q, idx_d;
  logic       msg_done_q, msg_done_d;
  logic       marker_q, marker_d;
  logic       hi_done_q, hi_done_d;
  logic       len_done_q, len_done_d;
  logic [2:0] count_c;

  assign count_c = !in_last_i ? FULL_BYTES :
                   (in_bytes_i > FULL_BYTES) ? FULL_BYTES : in_bytes_i;

  always_comb begin
    state_d    = state_q;
    round_d    = round_q;
    pos_d      = pos_q;
    idx_d      = idx_q;
    msg_done_d = msg_done_q;
    marker_d   = marker_q;
    hi_done_d  = hi_done_q;
    len_done_d = len_done_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;

    cmd_o             = '0;
    cmd_o.src         = SRC_INPUT;
    cmd_o.byte_count  = count_c;
    cmd_o.round_idx   = round_q;
    cmd_o.out_idx     = idx_q;

    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.push        = 1'b1;
          cmd_o.src         = SRC_INPUT;
          cmd_o.pad_in_word = in_last_i && (count_c != FULL_BYTES);
          cmd_o.len_add     = 1'b1;
          pos_d = pos_q + 4'd1;
          if (in_last_i) begin
            msg_done_d = 1'b1;
            marker_d   = (count_c == FULL_BYTES);
          end
          if (pos_q == POS_LEN_LO) begin
            cmd_o.work_load = 1'b1;
            round_d = '0;
            state_d = S_ROUND;
          end else if (in_last_i) begin
            state_d = S_PAD;
          end
        end
      end
      S_ROUND: begin
        cmd_o.round_en = 1'b1;
        round_d = round_q + 7'd1;
        if (round_q == ROUND_LAST) begin
          round_d = '0;
          state_d = S_FINAL;
        end
      end
      S_FINAL: begin
        cmd_o.chain_add = 1'b1;
        if (len_done_q) begin
          idx_d   = '0;
          state_d = S_OUT;
        end else if (msg_done_q) begin
          state_d = S_PAD;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_PAD: begin
        cmd_o.push = 1'b1;
        pos_d = pos_q + 4'd1;
        if (marker_q) begin
          cmd_o.src = SRC_MARKER;
          marker_d  = 1'b0;
        end else if (pos_q == POS_LEN_HI) begin
          cmd_o.src = SRC_LEN_HI;
          hi_done_d = 1'b1;
        end else if (pos_q == POS_LEN_LO && hi_done_q) begin
          cmd_o.src  = SRC_LEN_LO;
          len_done_d = 1'b1;
        end else begin
          cmd_o.src = SRC_ZERO;
        end
        if (pos_q == POS_LEN_LO) begin
          cmd_o.work_load = 1'b1;
          round_d = '0;
          state_d = S_ROUND;
        end
      end
      S_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          idx_d = idx_q + 3'd1;
          if (idx_q == LAST_IDX) begin
            cmd_o.chain_init = 1'b1;
            idx_d      = '0;
            pos_d      = '0;
            msg_done_d = 1'b0;
            marker_d   = 1'b0;
            hi_done_d  = 1'b0;
            len_done_d = 1'b0;
            state_d    = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      round_q    <= '0;
      pos_q      <= '0;
      idx_q      <= '0;
      msg_done_q <= 1'b0;
      marker_q   <= 1'b0;
      hi_done_q  <= 1'b0;
      len_done_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      round_q    <= round_d;
      pos_q      <= pos_d;
      idx_q      <= idx_d;
      msg_done_q <= msg_done_d;
      marker_q   <= marker_d;
      hi_done_q  <= hi_done_d;
      len_done_q <= len_done_d;
    end
  end

endmodule

// ===== src/sha1de_datapath.sv =====
// sha1de_datapath: schedule window, working variables, chaining words and length
// depends on sha1de_pkg

module sha1de_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [31:0]       in_word_i,
  input  sha1de_pkg::cmd_t  cmd_i,
  output logic [31:0]       digest_o
);
  import sha1de_pkg::*;

  logic [WORD_W-1:0] win_q [WIN_DEPTH];
  logic [WORD_W-1:0] work_q [NUM_HASH];
  logic [WORD_W-1:0] chain_q [NUM_HASH];
  logic [LEN_W-1:0]  len_q;

  logic [WORD_W-1:0] push_word;
  logic [WORD_W-1:0] wt;
  logic [WORD_W-1:0] fn;
  logic [WORD_W-1:0] kc;
  logic [WORD_W-1:0] temp;
  logic [WORD_W-1:0] shift_in;
  logic [WORD_W-1:0] iv [NUM_HASH];

  assign iv[0] = IV_0;
  assign iv[1] = IV_1;
  assign iv[2] = IV_2;
  assign iv[3] = IV_3;
  assign iv[4] = IV_4;

  always_comb begin
    case (cmd_i.src)
      SRC_INPUT:  push_word = cmd_i.pad_in_word ?
                              pad_last_word(in_word_i, cmd_i.byte_count) : in_word_i;
      SRC_MARKER: push_word = PAD_MARKER;
      SRC_LEN_HI: push_word = len_q[LEN_W-1:29];
      SRC_LEN_LO: push_word = {len_q[28:0], 3'b000};
      default:    push_word = '0;
    endcase
  end

  // oldest word sits in entry 0
  assign wt = (cmd_i.round_idx < ROUND_SCHED) ? win_q[0] :
              rotl1(win_q[13] ^ win_q[8] ^ win_q[2] ^ win_q[0]);

  always_comb begin
    if (cmd_i.round_idx < ROUND_P1) begin
      fn = (work_q[1] & work_q[2]) | (~work_q[1] & work_q[3]);
      kc = K_0;
    end else if (cmd_i.round_idx < ROUND_P2) begin
      fn = work_q[1] ^ work_q[2] ^ work_q[3];
      kc = K_1;
    end else if (cmd_i.round_idx < ROUND_P3) begin
      fn = (work_q[1] & work_q[2]) | (work_q[1] & work_q[3]) | (work_q[2] & work_q[3]);
      kc = K_2;
    end else begin
      fn = work_q[1] ^ work_q[2] ^ work_q[3];
      kc = K_3;
    end
  end

  assign temp     = rotl5(work_q[0]) + fn + work_q[4] + kc + wt;
  assign shift_in = cmd_i.round_en ? wt : push_word;

  always_ff @(posedge clk_i) begin
    if (cmd_i.push || cmd_i.round_en) begin
      for (int i = 0; i < WIN_DEPTH - 1; i++) begin
        win_q[i] <= win_q[i+1];
      end
      win_q[WIN_DEPTH-1] <= shift_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_HASH; i++) begin
        work_q[i]  <= '0;
        chain_q[i] <= iv[i];
      end
      len_q <= '0;
    end else begin
      if (cmd_i.work_load) begin
        for (int i = 0; i < NUM_HASH; i++) begin
          work_q[i] <= chain_q[i];
        end
      end else if (cmd_i.round_en) begin
        work_q[0] <= temp;
        work_q[1] <= work_q[0];
        work_q[2] <= rotl30(work_q[1]);
        work_q[3] <= work_q[2];
        work_q[4] <= work_q[3];
      end
      if (cmd_i.chain_init) begin
        for (int i = 0; i < NUM_HASH; i++) begin
          chain_q[i] <= iv[i];
        end
      end else if (cmd_i.chain_add) begin
        for (int i = 0; i < NUM_HASH; i++) begin
          chain_q[i] <= chain_q[i] + work_q[i];
        end
      end
      if (cmd_i.chain_init) begin
        len_q <= '0;
      end else if (cmd_i.len_add) begin
        len_q <= len_q + LEN_W'(cmd_i.byte_count);
      end
    end
  end

  always_comb begin
    case (cmd_i.out_idx)
      3'd0:    digest_o = chain_q[0];
      3'd1:    digest_o = chain_q[1];
      3'd2:    digest_o = chain_q[2];
      3'd3:    digest_o = chain_q[3];
      default: digest_o = chain_q[4];
    endcase
  end

endmodule

// ===== src/sha1_digest_engine.sv =====
// sha1_digest_engine: one message word taken per cycle between blocks; each full
// 16-word block then runs 80 rounds at one per cycle in the single round unit, then
// the chaining add. after the last word, padding pushes one word per cycle between
// blocks (up to two blocks), then the five digest words follow, one transaction each.
// rst_ni (async, active low) loads the initial hash, clears length and counters; the
// schedule window is not reset.

module sha1_digest_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  sha1de_in_if.sink   in_i,
  sha1de_out_if.source out_o
);
  import sha1de_pkg::*;

  cmd_t        cmd;
  logic [31:0] digest;

  sha1de_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_bytes_i  (in_i.valid_bytes),
    .in_last_i   (in_i.last_word),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd)
  );

  sha1de_datapath u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_word_i (in_i.data_word),
    .cmd_i     (cmd),
    .digest_o  (digest)
  );

  assign out_o.digest_word = digest;
  assign out_o.word_index  = cmd.out_idx;
  assign out_o.last_digest = (cmd.out_idx == LAST_IDX);

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// tb_top: self-checking testbench for sha1_digest_engine, with an in-bench sha-1 predictor
// that computes each expected digest from the accepted words and checks every output word
// depends on sha1de_in_if, sha1de_out_if (src/sha1de_if.sv) and the engine rtl

module tb_top;

  localparam int unsigned CYCLE_LIMIT  = 300000;
  localparam int unsigned DRAIN_CYCLES = 250;
  localparam int unsigned RANDOM_WORDS = 180;
  localparam int unsigned MAX_REPORTS  = 10;

  localparam logic [31:0] SHA1_K0 = 32'h5A82_7999;
  localparam logic [31:0] SHA1_K1 = 32'h6ED9_EBA1;
  localparam logic [31:0] SHA1_K2 = 32'h8F1B_BCDC;
  localparam logic [31:0] SHA1_K3 = 32'hCA62_C1D6;
  localparam logic [31:0] END_MARK = 32'h8000_0000;
  localparam int unsigned LEN_SLOT = 14;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_t;

  logic clk;
  logic rst_n;

  sha1de_in_if  in_if ();
  sha1de_out_if out_if ();

  sha1_digest_engine i_dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // predictor state
  logic [31:0] chain [5];
  logic [31:0] window [16];
  int unsigned fill_pos;
  logic [60:0] byte_len;
  digest_t     digest_fifo [$];

  int unsigned mismatch_cnt;
  int unsigned cycle_cnt;
  int unsigned burst_left;
  int unsigned gap_max;
  int unsigned random_words;

  int unsigned sink_mode;
  int unsigned sink_cnt;
  int unsigned sink_hold;
  int unsigned sink_phase;

  function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned s);
    return (x << s) | (x >> (32 - s));
  endfunction

  function automatic void restart_message();
    chain[0] = 32'h6745_2301;
    chain[1] = 32'hEFCD_AB89;
    chain[2] = 32'h98BA_DCFE;
    chain[3] = 32'h1032_5476;
    chain[4] = 32'hC3D2_E1F0;
    fill_pos = 0;
    byte_len = '0;
  endfunction

  function automatic void compress_block();
    logic [31:0] a, b, c, d, e, f, k, t;
    a = chain[0];
    b = chain[1];
    c = chain[2];
    d = chain[3];
    e = chain[4];
    for (int r = 0; r < 80; r++) begin
      if (r >= 16) begin
        window[r % 16] = rotl(window[(r + 13) % 16] ^ window[(r + 8) % 16]
                              ^ window[(r + 2) % 16] ^ window[r % 16], 1);
      end
      if (r < 20) begin
        f = (b & c) | (~b & d);
        k = SHA1_K0;
      end else if (r < 40) begin
        f = b ^ c ^ d;
        k = SHA1_K1;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = SHA1_K2;
      end else begin
        f = b ^ c ^ d;
        k = SHA1_K3;
      end
      t = rotl(a, 5) + f + e + k + window[r % 16];
      e = d;
      d = c;
      c = rotl(b, 30);
      b = a;
      a = t;
    end
    chain[0] = chain[0] + a;
    chain[1] = chain[1] + b;
    chain[2] = chain[2] + c;
    chain[3] = chain[3] + d;
    chain[4] = chain[4] + e;
  endfunction

  function automatic void absorb_word(input logic [31:0] w);
    window[fill_pos] = w;
    fill_pos = (fill_pos + 1) % 16;
    if (fill_pos == 0) compress_block();
  endfunction

  function automatic void predict_word(input logic [31:0] w, input logic [2:0] n,
                                       input logic last);
    int unsigned cnt;
    logic [31:0] keep;
    logic [63:0] bit_len;
    digest_t     d;
    if (!last) begin
      byte_len = byte_len + 61'd4;
      absorb_word(w);
      return;
    end
    cnt = (n > 3'd4) ? 4 : n;
    byte_len = byte_len + 61'(cnt);
    if (cnt == 4) begin
      absorb_word(w);
      absorb_word(END_MARK);
    end else begin
      keep = (cnt == 0) ? 32'h0 : (32'hFFFF_FFFF << (8 * (4 - cnt)));
      absorb_word((w & keep) | (32'h80 << (8 * (3 - cnt))));
    end
    while (fill_pos != LEN_SLOT) absorb_word(32'h0);
    bit_len = {byte_len, 3'b000};
    absorb_word(bit_len[63:32]);
    absorb_word(bit_len[31:0]);
    for (int j = 0; j < 5; j++) begin
      d.word = chain[j];
      d.idx  = 3'(j);
      d.last = (j == 4);
      digest_fifo.push_back(d);
    end
    restart_message();
  endfunction

  // drive one word, wait for the transaction, then maybe idle
  task automatic send_word(input logic [31:0] w, input logic [2:0] n, input logic last);
    int unsigned gap;
    in_if.valid       <= 1'b1;
    in_if.data_word   <= w;
    in_if.valid_bytes <= n;
    in_if.last_word   <= last;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    predict_word(w, n, last);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap != 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  function automatic logic [31:0] pick_data();
    case ($urandom_range(0, 7))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_empty_message();
    send_word($urandom, 3'd0, 1'b1);
  endtask

  // trailing bytes past the count carry junk that must be dropped
  task automatic test_partial_last_word();
    send_word(32'h6162_63FF, 3'd3, 1'b1);
    send_word(32'hFFFF_FFFF, 3'd1, 1'b1);
    send_word(32'hA5C3_FFFF, 3'd2, 1'b1);
  endtask

  task automatic test_count_above_four();
    for (int n = 5; n <= 7; n++) send_word($urandom, 3'(n), 1'b1);
  endtask

  task automatic test_short_nonlast_word();
    send_word(32'h0000_0000, 3'd1, 1'b0);
    send_word(32'hFFFF_FFFF, 3'd2, 1'b0);
    send_word($urandom, 3'd4, 1'b1);
  endtask

  // 56 bytes leaves no room for the length, so padding spills into a second block
  task automatic test_second_pad_block();
    for (int i = 0; i < 13; i++) send_word($urandom, 3'd4, 1'b0);
    send_word($urandom, 3'd4, 1'b1);
  endtask

  task automatic test_random_messages();
    int unsigned len;
    while (random_words < RANDOM_WORDS) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 16);
      gap_max = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      for (int i = 1; i < len; i++) send_word(pick_data(), 3'($urandom_range(0, 7)), 1'b0);
      send_word(pick_data(), 3'($urandom_range(0, 7)), 1'b1);
      random_words += len;
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result checker and stall pattern of the receiving side
  always @(posedge clk) begin
    digest_t got;
    digest_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      got.word = out_if.digest_word;
      got.idx  = out_if.word_index;
      got.last = out_if.last_digest;
      if (digest_fifo.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS)
          $display("unexpected digest transaction: word %h idx %0d last %0b",
                   got.word, got.idx, got.last);
      end else begin
        want = digest_fifo.pop_front();
        if (got !== want) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_REPORTS)
            $display("digest mismatch: expected word %h idx %0d last %0b, got %h idx %0d last %0b",
                     want.word, want.idx, want.last, got.word, got.idx, got.last);
        end
      end
    end
    if (sink_cnt == 0) begin
      sink_mode = $urandom_range(0, 3);
      sink_cnt  = $urandom_range(16, 96);
    end else begin
      sink_cnt--;
    end
    sink_phase++;
    case (sink_mode)
      0: out_if.ready <= 1'b1;
      1: out_if.ready <= 1'($urandom_range(0, 1));
      2: out_if.ready <= (sink_phase % 4 == 0);
      default: begin
        if (sink_hold == 0) begin
          sink_hold = $urandom_range(0, 12);
          out_if.ready <= 1'b1;
        end else begin
          sink_hold--;
          out_if.ready <= 1'b0;
        end
      end
    endcase
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    mismatch_cnt = 0;
    random_words = 0;
    burst_left   = 1;
    gap_max      = 3;
    sink_mode    = 0;
    sink_cnt     = 0;
    sink_hold    = 0;
    sink_phase   = 0;
    restart_message();
    for (int i = 0; i < 16; i++) window[i] = '0;
    rst_n             <= 1'b0;
    in_if.valid       <= 1'b0;
    in_if.data_word   <= '0;
    in_if.valid_bytes <= '0;
    in_if.last_word   <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    test_empty_message();
    test_partial_last_word();
    test_count_above_four();
    test_short_nonlast_word();
    test_second_pad_block();
    test_random_messages();
    in_if.valid <= 1'b0;

    while (digest_fifo.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
